[design/mf3_pkg.sv]
package mf3_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int WIDTH_RST = 1024;
  localparam logic [1:0] ROW_FULL = 2'd2;

  // one window column, sorted ascending
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  // window of an item that yields results, plus its flags
  typedef struct packed {
    col_t c0;      // oldest column
    col_t c1;
    col_t c2;      // newest column
    logic last;    // last input of the row, adds the trailing border result
    logic border;  // output column zero
  } item_t;

  function automatic logic [PIX_W-1:0] min2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                 logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] l;
    logic [PIX_W-1:0] h;
    col_t r;
    l = min2(a, b);
    h = max2(a, b);
    if (c < l) begin
      r.lo = c;
      r.md = l;
      r.hi = h;
    end else if (c > h) begin
      r.lo = l;
      r.md = h;
      r.hi = c;
    end else begin
      r.lo = l;
      r.md = c;
      r.hi = h;
    end
    return r;
  endfunction

endpackage

[design/median_filter_3x3_stream_unit.sv]
// out_tvalid rises once an input transfer has passed the line store read with column sort,
// the median input register, and the median select into the output register; the trailing
// border result of a row follows once the row's last result is taken
// throughput: one pixel per cycle while out_tready stays high, set by the read and write of
// both line stores for each pixel; the last pixel of an output row yields two results
// reset (synchronous, rst_n low): counts and window cleared, image_width back to 1024,
// line stores keep their contents and need no clearing pass
module median_filter_3x3_stream_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration: image_width
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data,
  // input pixels
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] pixel_in
  input  logic                      in_tuser,   // [0] slice_start
  // filtered pixels
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [7:0] pixel_out
  output logic                      out_tuser,  // [0] end_of_row
  output logic                      out_tlast   // last_in_run
);
  import mf3_pkg::*;

  logic [CFG_W-1:0] width_r;
  logic             m_valid, m_ready;
  item_t            m_item;

  // the user must write this register only while idle (not enforced here), so it is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_W'(WIDTH_RST);
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  // counters, both line stores with write-back forwarding, and the window of sorted columns
  mf3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .width_i  (width_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pix   (in_tdata),
    .in_start (in_tuser),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_item   (m_item)
  );

  // median of nine from three sorted columns, then the output register
  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_item    (m_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_tdata),
    .out_eor   (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

[design/mf3_line_buf.sv]
module mf3_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mf3_pkg::CFG_W-1:0]  width_i,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mf3_pkg::PIX_W-1:0]  in_pix,
  input  logic                       in_start,
  output logic                       m_valid,
  input  logic                       m_ready,
  output mf3_pkg::item_t             m_item
);
  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [AW-1:0] col_cnt_r;
  logic [1:0]    row_cnt_r;

  logic [EW-1:0] cfg_ext, eff_w, wm1, col_ext;
  logic [AW-1:0] col;
  logic [1:0]    row_cur;
  logic          last, has_out, border, in_xfer;

  // read stage
  logic             b_valid_r, b_last_r, b_out_r, b_border_r;
  logic [PIX_W-1:0] b_px_r;
  logic [AW-1:0]    b_addr_r;
  logic [PIX_W-1:0] top_rd_r, mid_rd_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_top_r, fwd_mid_r;
  logic [PIX_W-1:0] b_top, b_mid;
  col_t             b_col;
  logic             b_move;

  col_t win0_r, win1_r;

  always_comb begin
    cfg_ext = EW'(width_i);
    if (cfg_ext < EW'(3)) begin
      eff_w = EW'(3);
    end else if (cfg_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = cfg_ext;
    end
    wm1     = eff_w - EW'(1);
    col     = in_start ? '0 : col_cnt_r;
    row_cur = in_start ? 2'd0 : row_cnt_r;
    col_ext = EW'(col);
    last    = col_ext >= wm1;
    has_out = (row_cur == ROW_FULL) && (col != '0);
    border  = col == AW'(1);
  end

  assign b_move   = b_valid_r && (!b_out_r || m_ready);
  assign in_ready = !b_valid_r || b_move;
  assign in_xfer  = in_valid && in_ready;

  // same entry written by the leaving item while it is read
  assign b_top = fwd_r ? fwd_top_r : top_rd_r;
  assign b_mid = fwd_r ? fwd_mid_r : mid_rd_r;
  assign b_col = sort3(b_top, b_mid, b_px_r);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      top_rd_r <= upper_mem[col];
      mid_rd_r <= middle_mem[col];
    end
    if (b_move) begin
      upper_mem[b_addr_r]  <= b_mid;
      middle_mem[b_addr_r] <= b_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= 2'd0;
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
      win0_r    <= '0;
      win1_r    <= '0;
    end else begin
      if (in_xfer) begin
        col_cnt_r <= last ? '0 : col + AW'(1);
        row_cnt_r <= (last && row_cur != ROW_FULL) ? row_cur + 2'd1 : row_cur;
        b_valid_r <= 1'b1;
        fwd_r     <= b_move && (b_addr_r == col);
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) begin
        win0_r <= win1_r;
        win1_r <= b_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_px_r     <= in_pix;
      b_addr_r   <= col;
      b_last_r   <= last;
      b_out_r    <= has_out;
      b_border_r <= border;
      fwd_top_r  <= b_mid;
      fwd_mid_r  <= b_px_r;
    end
  end

  assign m_valid       = b_valid_r && b_out_r;
  assign m_item.c0     = win0_r;
  assign m_item.c1     = win1_r;
  assign m_item.c2     = b_col;
  assign m_item.last   = b_last_r;
  assign m_item.border = b_border_r;

endmodule

[design/mf3_median.sv]
module mf3_median (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      m_valid,
  output logic                      m_ready,
  input  mf3_pkg::item_t            m_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mf3_pkg::PIX_W-1:0] out_pix,
  output logic                      out_eor,
  output logic                      out_last
);
  import mf3_pkg::*;

  logic             c_valid_r;
  item_t            c_item_r;
  logic             d_valid_r, d_extra_r, d_eor_r, d_last_r;
  logic [PIX_W-1:0] d_pix_r;
  logic [PIX_W-1:0] lo_max, md_med, hi_min, med;
  logic             d_free, c_move, out_xfer;

  always_comb begin
    lo_max = max2(max2(c_item_r.c0.lo, c_item_r.c1.lo), c_item_r.c2.lo);
    md_med = med3(c_item_r.c0.md, c_item_r.c1.md, c_item_r.c2.md);
    hi_min = min2(min2(c_item_r.c0.hi, c_item_r.c1.hi), c_item_r.c2.hi);
    med    = med3(lo_max, md_med, hi_min);
  end

  assign out_xfer = d_valid_r && out_ready;
  assign d_free   = !d_valid_r || (out_ready && !d_extra_r);
  assign c_move   = c_valid_r && d_free;
  assign m_ready  = !c_valid_r || c_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      d_extra_r <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        c_valid_r <= 1'b1;
      end else if (c_move) begin
        c_valid_r <= 1'b0;
      end
      if (c_move) begin
        d_valid_r <= 1'b1;
        d_extra_r <= c_item_r.last;
      end else if (out_xfer) begin
        d_valid_r <= d_extra_r;
        d_extra_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && m_ready) begin
      c_item_r <= m_item;
    end
    if (c_move) begin
      d_pix_r  <= c_item_r.border ? '0 : med;
      d_eor_r  <= 1'b0;
      d_last_r <= !c_item_r.last;
    end else if (out_xfer && d_extra_r) begin
      d_pix_r  <= '0;
      d_eor_r  <= 1'b1;
      d_last_r <= 1'b1;
    end
  end

  assign out_valid = d_valid_r;
  assign out_pix   = d_pix_r;
  assign out_eor   = d_eor_r;
  assign out_last  = d_last_r;

endmodule
